### rtl/core/mpd_pkg.sv
// mpd_pkg: shared types, codes and the letter table for the morse pulse decoder
// used by mpd_core, morse_pulse_decoder and mpd_checker; depends on nothing
`default_nettype none

package mpd_pkg;

    // event kinds on the input channel
    localparam logic [1:0] REQ_RISE = 2'd0;
    localparam logic [1:0] REQ_FALL = 2'd1;
    localparam logic [1:0] REQ_OVF  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DOT    = 2'd0;
    localparam logic [1:0] KIND_DASH   = 2'd1;
    localparam logic [1:0] KIND_LETTER = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DOT_MIN  = 2'd0;
    localparam logic [1:0] REG_DASH_MIN = 2'd1;
    localparam logic [1:0] REG_GAP_MIN  = 2'd2;
    localparam logic [1:0] REG_GAP_MAX  = 2'd3;

    // register reset values
    localparam logic [15:0] DOT_MIN_RST  = 16'd500;
    localparam logic [15:0] DASH_MIN_RST = 16'd3000;
    localparam logic [15:0] GAP_MIN_RST  = 16'd8000;
    localparam logic [15:0] GAP_MAX_RST  = 16'd30000;

    // symbol counting
    localparam logic [2:0] MAX_SYMBOLS    = 3'd4;
    localparam logic [2:0] OVERLONG_COUNT = 3'd5;

    // letter emitted for an empty pattern
    localparam logic [6:0] EMPTY_LETTER = 7'h21;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] timestamp;
    } mpd_in_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [6:0] letter;
        logic       letter_valid;
    } mpd_out_t;

    typedef struct packed {
        logic [15:0] dot_min;
        logic [15:0] dash_min;
        logic [15:0] gap_min;
        logic [15:0] gap_max;
    } mpd_cfg_t;

    typedef struct packed {
        logic [15:0] start_time;
        logic [2:0]  symbol_count;
        logic [3:0]  symbol_pattern;
    } mpd_state_t;

    // letter by (1 << count) - 2 + pattern, zero where no letter exists
    function automatic logic [6:0] letter_at(input logic [4:0] idx);
        logic [6:0] ch;
        case (idx)
            5'd0:    ch = 7'h45; // E
            5'd1:    ch = 7'h54; // T
            5'd2:    ch = 7'h49; // I
            5'd3:    ch = 7'h4E; // N
            5'd4:    ch = 7'h41; // A
            5'd5:    ch = 7'h4D; // M
            5'd6:    ch = 7'h53; // S
            5'd7:    ch = 7'h44; // D
            5'd8:    ch = 7'h52; // R
            5'd9:    ch = 7'h47; // G
            5'd10:   ch = 7'h55; // U
            5'd11:   ch = 7'h4B; // K
            5'd12:   ch = 7'h57; // W
            5'd13:   ch = 7'h4F; // O
            5'd14:   ch = 7'h48; // H
            5'd15:   ch = 7'h42; // B
            5'd16:   ch = 7'h4C; // L
            5'd17:   ch = 7'h5A; // Z
            5'd18:   ch = 7'h46; // F
            5'd19:   ch = 7'h43; // C
            5'd20:   ch = 7'h50; // P
            5'd22:   ch = 7'h56; // V
            5'd23:   ch = 7'h58; // X
            5'd25:   ch = 7'h51; // Q
            5'd27:   ch = 7'h59; // Y
            5'd28:   ch = 7'h4A; // J
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/core/morse_pulse_decoder.sv
// morse_pulse_decoder: Morse decoder top level, input register, state, result register, APB
// depends on mpd_pkg and mpd_core
//
// Takes one edge or overflow event per cycle and returns at most one item per event: a dot
// or dash echo, or a decoded letter. An accepted event is held in the input register, is
// decoded by a single subtract, compare and table lookup, and lands in the result register.
// Throughput is one event per cycle; the input stalls only while a result waits and m_ready
// is low. The four 16-bit bounds sit at APB byte addresses 0, 4, 8 and 12 and are meant to
// be written while no event is in flight. No clearing pass after reset.
`default_nettype none

module morse_pulse_decoder (
    input  wire                              aclk,
    input  wire                              aresetn,
    // event channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  mpd_pkg::mpd_in_t                 s_data,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output mpd_pkg::mpd_out_t                m_data,
    // configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mpd_pkg::PADDR_W-1:0]      paddr,
    input  wire  [mpd_pkg::PDATA_W-1:0]      pwdata,
    output logic [mpd_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    logic                in_valid_reg;
    mpd_pkg::mpd_in_t    in_item_reg;
    mpd_pkg::mpd_state_t state_reg;
    mpd_pkg::mpd_state_t state_next;
    mpd_pkg::mpd_cfg_t   cfg_reg;
    logic                out_valid_reg;
    mpd_pkg::mpd_out_t   out_data_reg;
    mpd_pkg::mpd_out_t   res;
    logic                res_valid;
    logic                advance;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    mpd_core u_core (
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .st        (state_reg),
        .st_next   (state_next),
        .res       (res),
        .res_valid (res_valid)
    );

    // the held item moves on unless its result would find the result register blocked
    assign advance = in_valid_reg && (!res_valid || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // decoder state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot_min  <= mpd_pkg::DOT_MIN_RST;
            cfg_reg.dash_min <= mpd_pkg::DASH_MIN_RST;
            cfg_reg.gap_min  <= mpd_pkg::GAP_MIN_RST;
            cfg_reg.gap_max  <= mpd_pkg::GAP_MAX_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mpd_pkg::REG_DOT_MIN:  cfg_reg.dot_min  <= pwdata[15:0];
                mpd_pkg::REG_DASH_MIN: cfg_reg.dash_min <= pwdata[15:0];
                mpd_pkg::REG_GAP_MIN:  cfg_reg.gap_min  <= pwdata[15:0];
                mpd_pkg::REG_GAP_MAX:  cfg_reg.gap_max  <= pwdata[15:0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            mpd_pkg::REG_DOT_MIN:  prdata = {16'd0, cfg_reg.dot_min};
            mpd_pkg::REG_DASH_MIN: prdata = {16'd0, cfg_reg.dash_min};
            mpd_pkg::REG_GAP_MIN:  prdata = {16'd0, cfg_reg.gap_min};
            mpd_pkg::REG_GAP_MAX:  prdata = {16'd0, cfg_reg.gap_max};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/mpd_core.sv
// mpd_core: per-item decode logic, pulse width, classification and letter lookup
// depends on mpd_pkg
`default_nettype none

module mpd_core (
    input  mpd_pkg::mpd_in_t    item,
    input  mpd_pkg::mpd_cfg_t   cfg,
    input  mpd_pkg::mpd_state_t st,
    output mpd_pkg::mpd_state_t st_next,
    output mpd_pkg::mpd_out_t   res,
    output logic                res_valid
);

    logic [15:0] width;
    logic        is_dot;
    logic        is_dash;
    logic        is_end;
    logic [4:0]  tbl_idx;
    logic [6:0]  tbl_ch;
    logic [4:0]  base_idx;

    // wrapping pulse width and its class
    assign width   = item.timestamp - st.start_time;
    assign is_dot  = (width > cfg.dot_min) && (width < cfg.dash_min);
    assign is_dash = !is_dot && (width >= cfg.dash_min) && (width < cfg.gap_min);
    assign is_end  = !is_dot && !is_dash && (width >= cfg.gap_min) && (width < cfg.gap_max);

    // table index for patterns of one to four symbols
    assign base_idx = (5'd1 << st.symbol_count) - 5'd2;
    assign tbl_idx  = base_idx + {1'b0, st.symbol_pattern};
    assign tbl_ch   = mpd_pkg::letter_at(tbl_idx);

    always_comb begin
        st_next   = st;
        res       = '0;
        res_valid = 1'b0;
        case (item.req_type)
            mpd_pkg::REQ_RISE: begin
                st_next.start_time = item.timestamp;
            end
            mpd_pkg::REQ_FALL: begin
                st_next.start_time = '0;
                if (is_dot || is_dash) begin
                    res_valid    = 1'b1;
                    res.out_kind = is_dash ? mpd_pkg::KIND_DASH : mpd_pkg::KIND_DOT;
                    // append symbol, saturate at overlong
                    if (st.symbol_count < mpd_pkg::MAX_SYMBOLS) begin
                        st_next.symbol_pattern = st.symbol_pattern
                            | (4'(is_dash) << st.symbol_count[1:0]);
                        st_next.symbol_count = st.symbol_count + 3'd1;
                    end else begin
                        st_next.symbol_count = mpd_pkg::OVERLONG_COUNT;
                    end
                end else if (is_end) begin
                    res_valid    = 1'b1;
                    res.out_kind = mpd_pkg::KIND_LETTER;
                    if (st.symbol_count == 3'd0) begin
                        res.letter       = mpd_pkg::EMPTY_LETTER;
                        res.letter_valid = 1'b1;
                    end else if (st.symbol_count <= mpd_pkg::MAX_SYMBOLS) begin
                        res.letter       = tbl_ch;
                        res.letter_valid = (tbl_ch != 7'h00);
                    end
                    st_next.symbol_count   = '0;
                    st_next.symbol_pattern = '0;
                end
            end
            mpd_pkg::REQ_OVF: begin
                st_next.start_time = '0;
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/mpd_checker.sv
// mpd_checker: port-level checks for morse_pulse_decoder, bound to the top level
// depends on mpd_pkg
`default_nettype none

module mpd_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_ready,
    input wire                         m_valid,
    input wire                         m_ready,
    input mpd_pkg::mpd_out_t           m_data
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // symbol echoes carry no letter
    a_echo_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind != mpd_pkg::KIND_LETTER
        |-> m_data.letter == 7'd0 && !m_data.letter_valid)
        else $error("symbol echo with letter bits set");

    // a valid letter is never the null character
    a_letter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == mpd_pkg::KIND_LETTER && m_data.letter_valid
        |-> m_data.letter != 7'd0)
        else $error("valid letter with null code");

    // an input stall only happens while a result waits
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with result path free");

endmodule

bind morse_pulse_decoder mpd_checker u_mpd_checker (.*);

`default_nettype wire

### dv/morse_scoreboard_pkg.sv
// morse_scoreboard_pkg: decode predictor and result checker for the morse pulse decoder
// depends on mpd_pkg for the item structs, event and result codes, and register indexes

package morse_scoreboard_pkg;

    // marks a pattern slot with no letter in the morse order string
    localparam byte NO_LETTER = ".";

    class morse_scoreboard;

        // classification bounds, mirrored from the configuration port
        logic [15:0] dot_min;
        logic [15:0] dash_min;
        logic [15:0] gap_min;
        logic [15:0] gap_max;

        // decoder state
        logic [15:0] start_time;
        logic [2:0]  symbol_count;
        logic [3:0]  symbol_pattern;

        // letters by (1 << count) - 2 + pattern, dash is a one bit
        string       morse_order;

        mpd_pkg::mpd_out_t decoded_q[$];
        int          mismatches;

        function new();
            dot_min        = mpd_pkg::DOT_MIN_RST;
            dash_min       = mpd_pkg::DASH_MIN_RST;
            gap_min        = mpd_pkg::GAP_MIN_RST;
            gap_max        = mpd_pkg::GAP_MAX_RST;
            start_time     = '0;
            symbol_count   = '0;
            symbol_pattern = '0;
            morse_order    = "ETINAMSDRGUKWOHBLZFCP.VX.Q.YJ.";
            mismatches     = 0;
        endfunction

        function void set_bound(logic [1:0] idx, logic [15:0] value);
            case (idx)
                mpd_pkg::REG_DOT_MIN:  dot_min  = value;
                mpd_pkg::REG_DASH_MIN: dash_min = value;
                mpd_pkg::REG_GAP_MIN:  gap_min  = value;
                mpd_pkg::REG_GAP_MAX:  gap_max  = value;
                default: ;
            endcase
        endfunction

        // store up to four symbols, beyond that only mark the pattern overlong
        function void push_symbol(bit is_dash);
            if (symbol_count < mpd_pkg::MAX_SYMBOLS) begin
                symbol_pattern[symbol_count[1:0]] = is_dash;
                symbol_count = symbol_count + 3'd1;
            end else begin
                symbol_count = mpd_pkg::OVERLONG_COUNT;
            end
        endfunction

        // advance the decoder by one accepted event, queue the result it causes
        function void decode_event(mpd_pkg::mpd_in_t ev);
            logic [15:0]       width;
            mpd_pkg::mpd_out_t res;
            int                idx;
            byte               ch;
            res = '0;
            case (ev.req_type)
                mpd_pkg::REQ_RISE: start_time = ev.timestamp;
                mpd_pkg::REQ_OVF:  start_time = '0;
                mpd_pkg::REQ_FALL: begin
                    width = ev.timestamp - start_time;
                    if (width > dot_min && width < dash_min) begin
                        push_symbol(1'b0);
                        res.out_kind = mpd_pkg::KIND_DOT;
                        decoded_q.push_back(res);
                    end else if (width >= dash_min && width < gap_min) begin
                        push_symbol(1'b1);
                        res.out_kind = mpd_pkg::KIND_DASH;
                        decoded_q.push_back(res);
                    end else if (width >= gap_min && width < gap_max) begin
                        res.out_kind = mpd_pkg::KIND_LETTER;
                        if (symbol_count == 3'd0) begin
                            res.letter       = mpd_pkg::EMPTY_LETTER;
                            res.letter_valid = 1'b1;
                        end else if (symbol_count <= mpd_pkg::MAX_SYMBOLS) begin
                            idx = (1 << symbol_count) - 2 + symbol_pattern;
                            ch  = morse_order[idx];
                            if (ch != NO_LETTER) begin
                                res.letter       = ch[6:0];
                                res.letter_valid = 1'b1;
                            end
                        end
                        symbol_count   = '0;
                        symbol_pattern = '0;
                        decoded_q.push_back(res);
                    end
                    start_time = '0;
                end
                default: ;
            endcase
        endfunction

        // compare one accepted result with the oldest decoded one
        function void check_result(mpd_pkg::mpd_out_t got);
            mpd_pkg::mpd_out_t want;
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d letter %02h valid %0d",
                             got.out_kind, got.letter, got.letter_valid);
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_kind !== want.out_kind || got.letter !== want.letter ||
                    got.letter_valid !== want.letter_valid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected kind %0d letter %02h valid %0d, ",
                              "got kind %0d letter %02h valid %0d"},
                             want.out_kind, want.letter, want.letter_valid,
                             got.out_kind, got.letter, got.letter_valid);
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

    endclass

endpackage

### dv/morse_pulse_decoder_test.sv
// morse_pulse_decoder_test: drives edge and overflow items into the decoder and checks
// every dot, dash and letter result against the scoreboard's own decode
// depends on mpd_pkg, morse_scoreboard_pkg and the morse_pulse_decoder RTL

module morse_pulse_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         NUM_PHASES     = 8;
    localparam int         PHASE_ITEMS    = 198;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         WATCHDOG_LIMIT = 5000;

    bit          aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    mpd_pkg::mpd_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    mpd_pkg::mpd_out_t m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [mpd_pkg::PADDR_W-1:0] paddr;
    logic [mpd_pkg::PDATA_W-1:0] pwdata;
    logic [mpd_pkg::PDATA_W-1:0] prdata;
    logic        pready;

    morse_scoreboard_pkg::morse_scoreboard sb;
    bit          hold_req = 1'b0;
    int          burst_left = 0;
    int          items_sent = 0;
    int          stall_count = 0;
    int          rx_mode = 0;
    int          rx_left = 0;

    morse_pulse_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    // offer one item in bursts with random gaps, return at the falling edge after acceptance
    task automatic offer(logic [1:0] kind, logic [15:0] ts);
        mpd_pkg::mpd_in_t ev;
        ev.req_type  = kind;
        ev.timestamp = ts;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            if (!hold_req && $urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        burst_left--;
        if (kind != REQ_UNUSED)
            items_sent++;
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one pulse of the given width, with a rising edge or from the cleared start time
    task automatic pulse(logic [15:0] width);
        logic [15:0] t;
        if ($urandom_range(0, 1)) begin
            t = 16'($urandom_range(0, 16'hFFFF));
            offer(mpd_pkg::REQ_RISE, t);
            offer(mpd_pkg::REQ_FALL, t + width);
        end else begin
            offer(mpd_pkg::REQ_FALL, width);
        end
    endtask

    // a width in [lo, hi], often on a bound; any width when the range is empty
    function automatic logic [15:0] width_between(int lo, int hi);
        if (lo > hi)
            return 16'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 3))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // overflows, unused kinds, stray edges and pulses outside every class
    task automatic noise_item();
        case ($urandom_range(0, 4))
            0: offer(mpd_pkg::REQ_OVF, 16'($urandom_range(0, 16'hFFFF)));
            1: offer(REQ_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
            2: offer(mpd_pkg::REQ_RISE, 16'($urandom_range(0, 16'hFFFF)));
            3: offer(mpd_pkg::REQ_FALL, 16'($urandom_range(0, 16'hFFFF)));
            default: begin
                if ($urandom_range(0, 1))
                    pulse(width_between(0, int'(sb.dot_min)));
                else
                    pulse(width_between(int'(sb.gap_max), 16'hFFFF));
            end
        endcase
    endtask

    // apb write: setup phase, access phase, then back to idle
    task automatic write_bound(logic [1:0] idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // stop offering and let every expected result and any silent item leave the block
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(20, 150);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((rx_left % 5) < 3);
                endcase
            end
        end
    end

    // sample both channels and the config port at the rising edge, watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready)
                sb.set_bound(paddr[3:2], pwdata[15:0]);
            if (s_valid && s_ready)
                sb.decode_event(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                    (psel && penable && pwrite && pready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        mpd_pkg::mpd_cfg_t bounds;
        int       target;
        bit       hold_done;
        bit       is_dash;
        sb        = new();
        hold_done = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed items at the reset bounds, each fall measured from a cleared start
        offer(REQ_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
        offer(mpd_pkg::REQ_RISE, 16'hFFFF);
        // overflow clears the start, so this width sits on the dot bound and is ignored
        offer(mpd_pkg::REQ_OVF, 16'hFFFF);
        offer(mpd_pkg::REQ_FALL, sb.dot_min);
        offer(mpd_pkg::REQ_FALL, sb.dot_min + 16'd1);
        offer(mpd_pkg::REQ_FALL, sb.dash_min - 16'd1);
        offer(mpd_pkg::REQ_FALL, sb.dash_min);
        offer(mpd_pkg::REQ_FALL, sb.gap_max);
        offer(mpd_pkg::REQ_FALL, sb.gap_min);
        offer(mpd_pkg::REQ_FALL, sb.gap_min - 16'd1);
        offer(mpd_pkg::REQ_FALL, sb.gap_max - 16'd1);
        // empty pattern
        offer(mpd_pkg::REQ_FALL, sb.gap_min);
        // three dashes, the first across a timer wrap
        offer(mpd_pkg::REQ_RISE, 16'hFFF0);
        offer(mpd_pkg::REQ_FALL, 16'hFFF0 + sb.dash_min);
        repeat (2) offer(mpd_pkg::REQ_FALL, sb.dash_min);
        offer(mpd_pkg::REQ_FALL, sb.gap_min);
        // four dashes have no letter
        repeat (4) offer(mpd_pkg::REQ_FALL, sb.dash_min);
        offer(mpd_pkg::REQ_FALL, sb.gap_min);
        // overlong pattern
        repeat (5) offer(mpd_pkg::REQ_FALL, sb.dot_min + 16'd1);
        offer(mpd_pkg::REQ_FALL, sb.gap_min);

        // random phases, each under its own set of bounds
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: bounds = '{mpd_pkg::DOT_MIN_RST, mpd_pkg::DASH_MIN_RST,
                              mpd_pkg::GAP_MIN_RST, mpd_pkg::GAP_MAX_RST};
                1: bounds = '{16'd0, 16'd1, 16'd2, 16'd3};
                2: bounds = '{16'd100, 16'd300, 16'd700, 16'd2000};
                3: bounds = '{16'd0, 16'h4000, 16'h8000, 16'hFFFF};
                4: bounds = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                5: bounds = '0;
                6: begin
                    bounds.dot_min  = 16'($urandom_range(0, 2000));
                    bounds.dash_min = 16'(bounds.dot_min + $urandom_range(1, 5000));
                    bounds.gap_min  = 16'(bounds.dash_min + $urandom_range(1, 10000));
                    bounds.gap_max  = 16'(bounds.gap_min + $urandom_range(1, 20000));
                end
                default: bounds = {$urandom, $urandom};
            endcase
            drain();
            write_bound(mpd_pkg::REG_DOT_MIN, bounds.dot_min);
            write_bound(mpd_pkg::REG_DASH_MIN, bounds.dash_min);
            write_bound(mpd_pkg::REG_GAP_MIN, bounds.gap_min);
            write_bound(mpd_pkg::REG_GAP_MAX, bounds.gap_max);

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                // one long receiver hold-off while items keep coming
                if (phase == 0 && !hold_done && items_sent + PHASE_ITEMS > target + 60) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 9) < 8) begin
                    // a letter: up to five symbols with some noise, then a gap
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 15) == 0)
                            noise_item();
                        is_dash = 1'($urandom_range(0, 1));
                        if (is_dash)
                            pulse(width_between(int'(sb.dash_min), int'(sb.gap_min) - 1));
                        else
                            pulse(width_between(int'(sb.dot_min) + 1, int'(sb.dash_min) - 1));
                    end
                    pulse(width_between(int'(sb.gap_min), int'(sb.gap_max) - 1));
                end else begin
                    noise_item();
                end
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
